[design/kway_merge_selector_unit_assert.svh]
// ----------------------------------------------------------------------------
// kway_merge_selector_unit_assert.svh
// assertion macros used by the merge selector datapath
// ----------------------------------------------------------------------------
`ifndef KWAY_MERGE_SELECTOR_UNIT_ASSERT_SVH
`define KWAY_MERGE_SELECTOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// check on every clock edge outside reset
`define KMS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kms assertion failed");
// check on every clock edge, reset included
`define KMS_ASSERT_NORST(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("kms assertion failed");
`else
`define KMS_ASSERT(name, prop)
`define KMS_ASSERT_NORST(name, prop)
`endif
`endif

[design/kms_pkg.sv]
// ----------------------------------------------------------------------------
// kms_pkg
// shared widths, beat layout and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package kms_pkg;

  // field widths
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned KEY_W     = 32;
  // number of runs the index field can address
  localparam int unsigned RUN_SPACE = 1 << IDX_W;

  // beat layout: key and run index packed, zero padded to whole bytes
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_PAD_W   = M_TDATA_W - KEY_W - IDX_W;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // apply the input beat to the run state
    logic scan_start;  // clear the running minimum and the scan address
    logic issue;       // read one head and advance the scan address
    logic commit;      // load the selected result into the output register
  } kms_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic sel_ok;     // no run awaits a refill, selection may run
    logic scan_last;  // scan address points at the last run
    logic out_free;   // output register can take a result this cycle
  } kms_stat_t;

endpackage

`default_nettype wire

[design/kms_ctrl.sv]
// ----------------------------------------------------------------------------
// kms_ctrl
// sequencer for input acceptance, head scan and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module kms_ctrl
  import kms_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  kms_stat_t stat_i,
  output kms_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.sel_ok) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last compare lands this cycle
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/kms_datapath.sv]
// ----------------------------------------------------------------------------
// kms_datapath
// run state, head key memory, sequential minimum scan and output register
// ----------------------------------------------------------------------------
`default_nettype none

module kms_datapath
  import kms_pkg::*;
#(
  parameter int unsigned NUM_RUNS = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  kms_cmd_t         cmd_i,
  output kms_stat_t        stat_o,
  input  wire  [IDX_W-1:0] in_run_i,
  input  wire  [KEY_W-1:0] in_key_i,
  input  wire              in_exh_i,
  input  wire              out_ready_i,
  output logic             out_valid_o,
  output logic [KEY_W-1:0] out_key_o,
  output logic [IDX_W-1:0] out_run_o,
  output logic             out_done_o
);

  // runs past the index field cannot be refilled and block selection
  localparam int unsigned NumAddr = (NUM_RUNS < RUN_SPACE) ? NUM_RUNS : RUN_SPACE;
  localparam int unsigned AddrW   = $clog2(NumAddr);
  localparam int unsigned CntW    = $clog2(NumAddr + 1);
  localparam bit          Unreach = (NUM_RUNS > RUN_SPACE);

  logic [KEY_W-1:0] keys_mem [NumAddr];

  logic [NumAddr-1:0] valid_q, valid_d;
  logic [NumAddr-1:0] fin_q, fin_d;
  logic [CntW-1:0]    pend_cnt_q, pend_cnt_d;
  logic               done_q, done_d;

  logic [AddrW-1:0]   scan_addr_q;
  logic               cmp_en_q;
  logic               rd_valid_q;
  logic [AddrW-1:0]   rd_run_q;
  logic [KEY_W-1:0]   rd_key_q;

  logic               best_any_q;
  logic [KEY_W-1:0]   best_key_q;
  logic [AddrW-1:0]   best_run_q;

  logic               out_valid_q;
  logic [KEY_W-1:0]   out_key_q;
  logic [IDX_W-1:0]   out_run_q;
  logic               out_done_q;

  logic               in_range;
  logic [AddrW-1:0]   wr_idx;
  logic               upd_en;
  logic               wr_en;

  // input beat decode
  assign in_range = (32'(in_run_i) < NUM_RUNS);
  assign wr_idx   = in_run_i[AddrW-1:0];
  assign upd_en   = cmd_i.accept && !done_q && in_range;
  assign wr_en    = upd_en && !in_exh_i && !fin_q[wr_idx] && !valid_q[wr_idx];

  // run flags, awaiting-refill count and done flag
  always_comb begin
    valid_d    = valid_q;
    fin_d      = fin_q;
    pend_cnt_d = pend_cnt_q;
    done_d     = done_q;
    if (upd_en) begin
      if (in_exh_i) begin
        if (!fin_q[wr_idx]) begin
          fin_d[wr_idx] = 1'b1;
          if (!valid_q[wr_idx]) begin
            pend_cnt_d = pend_cnt_q - CntW'(1);
          end
        end
      end else if (wr_en) begin
        valid_d[wr_idx] = 1'b1;
        pend_cnt_d      = pend_cnt_q - CntW'(1);
      end
    end
    if (cmd_i.commit) begin
      if (best_any_q) begin
        valid_d[best_run_q] = 1'b0;
        if (!fin_q[best_run_q]) begin
          pend_cnt_d = pend_cnt_q + CntW'(1);
        end
      end else begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      fin_q      <= '0;
      pend_cnt_q <= CntW'(NumAddr);
      done_q     <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      fin_q      <= fin_d;
      pend_cnt_q <= pend_cnt_d;
      done_q     <= done_d;
    end
  end

  // head key memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      keys_mem[wr_idx] <= in_key_i;
    end
    if (cmd_i.issue) begin
      rd_key_q <= keys_mem[scan_addr_q];
    end
  end

  // scan address and read side tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      cmp_en_q    <= 1'b0;
      rd_valid_q  <= 1'b0;
      rd_run_q    <= '0;
    end else begin
      cmp_en_q <= cmd_i.issue;
      if (cmd_i.scan_start) begin
        scan_addr_q <= '0;
      end else if (cmd_i.issue) begin
        scan_addr_q <= scan_addr_q + AddrW'(1);
        rd_valid_q  <= valid_q[scan_addr_q];
        rd_run_q    <= scan_addr_q;
      end
    end
  end

  // running minimum, strict less-than keeps the lower run on ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_any_q <= 1'b0;
      best_run_q <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        best_any_q <= 1'b0;
      end else if (cmp_en_q && rd_valid_q && (!best_any_q || rd_key_q < best_key_q)) begin
        best_any_q <= 1'b1;
        best_run_q <= rd_run_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_q && rd_valid_q && (!best_any_q || rd_key_q < best_key_q)) begin
      best_key_q <= rd_key_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (best_any_q) begin
        out_key_q  <= best_key_q;
        out_run_q  <= IDX_W'(best_run_q);
        out_done_q <= 1'b0;
      end else begin
        out_key_q  <= '0;
        out_run_q  <= '0;
        out_done_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_run_o   = out_run_q;
  assign out_done_o  = out_done_q;

  // status to the controller
  assign stat_o.sel_ok    = (pend_cnt_q == '0) && !Unreach && !done_q;
  assign stat_o.scan_last = (scan_addr_q == AddrW'(NumAddr - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // checks
  `include "kway_merge_selector_unit_assert.svh"

  `KMS_ASSERT(a_pend_cnt_matches, $countones(~(valid_q | fin_q)) == int'(pend_cnt_q))
  `KMS_ASSERT(a_commit_needs_no_pending, cmd_i.commit |-> (pend_cnt_q == '0))
  `KMS_ASSERT(a_no_commit_after_done, done_q |-> !cmd_i.commit)
  `KMS_ASSERT(a_best_is_valid, (cmd_i.commit && best_any_q) |-> valid_q[best_run_q])

endmodule

`default_nettype wire

[design/kway_merge_selector_unit.sv]
// ----------------------------------------------------------------------------
// kway_merge_selector_unit
// k-way merge selector: holds one head key per run and emits the minimum
// ----------------------------------------------------------------------------
// usage
//   slave side: each beat either refills a run with its next key or marks
//   the run exhausted (tuser). master side: each beat carries the smallest
//   head key and its run, which the source must then refill; one final
//   beat with done set follows once every run is exhausted.
// timing
//   a beat that leaves some run awaiting a refill gives no result. a beat
//   that completes the set of heads starts a scan of the head key memory,
//   one run per cycle over its single read port; the result then waits
//   for the output register, and the slave side opens again in the cycle
//   after the result is loaded.
// reset
//   all runs await a refill, no head is held, no result is pending.
// stall
//   the result sits in an output register; new beats are taken while it
//   waits, and only a further result waits for the register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module kway_merge_selector_unit
  import kms_pkg::*;
#(
  parameter int unsigned NUM_RUNS = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // slave side
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire  [S_TDATA_W-1:0] s_axis_tdata_i,  // run_index[5:0], key[37:6], pad
  input  wire  [0:0]           s_axis_tuser_i,  // run_exhausted[0]
  // master side
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // merged_key[31:0], source_run[37:32], pad
  output logic [0:0]           m_axis_tuser_o   // done_res[0]
);

  kms_cmd_t         cmd;
  kms_stat_t        stat;
  logic [KEY_W-1:0] out_key;
  logic [IDX_W-1:0] out_run;
  logic             out_done;

  // sequencer
  kms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // run state, scan and output register
  kms_datapath #(
    .NUM_RUNS (NUM_RUNS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_run_i    (s_axis_tdata_i[IDX_W-1:0]),
    .in_key_i    (s_axis_tdata_i[IDX_W +: KEY_W]),
    .in_exh_i    (s_axis_tuser_i[0]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_key_o   (out_key),
    .out_run_o   (out_run),
    .out_done_o  (out_done)
  );

  // master beat packing
  assign m_axis_tdata_o = {{M_PAD_W{1'b0}}, out_run, out_key};
  assign m_axis_tuser_o = out_done;

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the k-way merge selector
// ----------------------------------------------------------------------------
// drives one complete merge of 64 runs through the slave side.
// - a short table of edge cases opens the merge: extreme keys, ties,
//   keys for held or finished runs, repeated exhaustion.
// - random refills follow. each one answers a run that awaits a refill,
//   at first the runs the table left empty, then the run that the last
//   merged key came from, with some stray beats mixed in. later refills
//   exhaust their runs until the done beat comes out. a behavioral copy
//   of the selector predicts every master-side beat, and an in-order queue
//   holds the predictions. both sides idle at random, except for one
//   window, and the receiver sometimes stalls for longer than a full scan.
// ----------------------------------------------------------------------------

module tb_top;
  import kms_pkg::*;

  localparam int RUNS         = RUN_SPACE;
  localparam int RANDOM_ITEMS = 420;
  localparam int TAIL_CYCLES  = 4 * (RUNS + 4);
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int QUIET_LO     = 12_000;
  localparam int QUIET_HI     = 24_000;
  localparam int IDLE_PCT     = 12;

  // one master-side beat, split into its fields
  typedef struct packed {
    logic [KEY_W-1:0] merged_key;
    logic [IDX_W-1:0] source_run;
    logic             done_res;
  } merge_beat_t;

  // one row of the opening table
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic             exh;
    logic             quiet;  // typed in: no beat while runs await a refill
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;

  int cyc = 0;
  int fail_cnt = 0;
  int n_sent = 0;
  int n_keys = 0;
  int n_done = 0;
  int stall_left = 0;

  merge_beat_t merge_q[$];

  // selector state as the bench sees it
  logic [KEY_W-1:0] head_key [RUNS];
  bit               head_ok  [RUNS];
  bit               run_done [RUNS];
  bit               all_done = 1'b0;

  // opening table: ties at both ends, edge keys, held and finished runs
  dir_row_t dir_rows [16] = '{
    '{6'd0,  32'h0000_0000, 1'b0, 1'b1},  // smallest key
    '{6'd63, 32'hFFFF_FFFF, 1'b0, 1'b1},  // largest key on the last run
    '{6'd0,  32'h0000_0005, 1'b0, 1'b1},  // key while a head is held
    '{6'd63, 32'h0000_0000, 1'b1, 1'b1},  // exhaust a run that holds a head
    '{6'd63, 32'h1234_5678, 1'b1, 1'b1},  // exhaust again
    '{6'd63, 32'h0000_0007, 1'b0, 1'b1},  // key for a finished run
    '{6'd1,  32'hFFFF_FFFF, 1'b1, 1'b1},  // exhaust before any key, key bits set
    '{6'd1,  32'h0000_0003, 1'b0, 1'b1},  // key after exhaustion
    '{6'd2,  32'h0000_0000, 1'b0, 1'b0},  // ties run 0 at the bottom
    '{6'd62, 32'hFFFF_FFFF, 1'b0, 1'b0},  // ties run 63 at the top
    '{6'd3,  32'h8000_0000, 1'b0, 1'b1},
    '{6'd4,  32'h7FFF_FFFF, 1'b0, 1'b1},
    '{6'd5,  32'h5555_5555, 1'b0, 1'b1},
    '{6'd6,  32'hAAAA_AAAA, 1'b0, 1'b1},
    '{6'd32, 32'h0000_0001, 1'b0, 1'b1},
    '{6'd31, 32'h0000_0000, 1'b1, 1'b1}
  };

  kway_merge_selector_unit #(
    .NUM_RUNS (RUNS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit in_quiet();
    return (cyc >= QUIET_LO) && (cyc < QUIET_HI);
  endfunction

  function automatic bit idle_roll();
    return !in_quiet() && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // apply one beat to the run state and select the next head, if allowed
  function automatic bit merge_step(input logic [IDX_W-1:0] idx,
                                    input logic [KEY_W-1:0] key,
                                    input bit exh,
                                    output merge_beat_t beat);
    bit               have;
    logic [KEY_W-1:0] best;
    int               best_run;
    beat     = '0;
    have     = 1'b0;
    best     = '0;
    best_run = 0;
    if (all_done)
      return 1'b0;
    if (exh) begin
      run_done[idx] = 1'b1;
    end else if (!run_done[idx] && !head_ok[idx]) begin
      head_key[idx] = key;
      head_ok[idx]  = 1'b1;
    end
    // nothing is selected while some run awaits a refill
    for (int r = 0; r < RUNS; r++)
      if (!head_ok[r] && !run_done[r])
        return 1'b0;
    // strict compare keeps the lower run on ties
    for (int r = 0; r < RUNS; r++) begin
      if (head_ok[r] && (!have || head_key[r] < best)) begin
        have     = 1'b1;
        best     = head_key[r];
        best_run = r;
      end
    end
    if (have) begin
      head_ok[best_run] = 1'b0;
      beat.merged_key   = best;
      beat.source_run   = best_run[IDX_W-1:0];
    end else begin
      all_done      = 1'b1;
      beat.done_res = 1'b1;
    end
    return 1'b1;
  endfunction

  // a run that awaits a refill, chosen at random; -1 if there is none
  function automatic int pick_waiting();
    int cand[$];
    for (int r = 0; r < RUNS; r++)
      if (!head_ok[r] && !run_done[r])
        cand.push_back(r);
    if (cand.size() == 0)
      return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // present one slave beat and wait until it is taken
  task automatic send_beat(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] key,
                           input logic exh);
    while (idle_roll()) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - KEY_W - IDX_W){1'b0}}, key, idx};
    s_tuser  <= exh;
    do @(posedge clk_i); while (!s_tready);
    n_sent++;
  endtask

  task automatic note_fail(input string what, input merge_beat_t want, input merge_beat_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("cycle %0d: %s", cyc, what);
      $display("  expected key=%h run=%0d done=%0b", want.merged_key, want.source_run,
               want.done_res);
      $display("  actual   key=%h run=%0d done=%0b", got.merged_key, got.source_run,
               got.done_res);
    end
  endtask

  // receiver: short random idles, now and then a stall longer than a scan
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!in_quiet() && $urandom_range(0, 999) == 0) begin
      stall_left <= $urandom_range(70, 150);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= !idle_roll();
    end
  end

  // check each master beat against the oldest prediction
  always @(posedge clk_i) begin
    merge_beat_t got;
    merge_beat_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.merged_key = m_tdata[KEY_W-1:0];
      got.source_run = m_tdata[KEY_W+IDX_W-1:KEY_W];
      got.done_res   = m_tuser[0];
      if (merge_q.size() == 0) begin
        note_fail("beat with nothing expected", '0, got);
      end else begin
        want = merge_q.pop_front();
        if (got.merged_key !== want.merged_key || got.source_run !== want.source_run ||
            got.done_res !== want.done_res)
          note_fail("field mismatch", want, got);
      end
      if (got.done_res)
        n_done++;
      else
        n_keys++;
    end
  end

  // cycle count and watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("timeout with %0d beats still expected", merge_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stim
    merge_beat_t      beat;
    bit               got;
    bit               ignored;
    int               run;
    int               counted;
    logic [KEY_W-1:0] key;
    bit               exh;
    foreach (head_key[r]) begin
      head_key[r] = '0;
      head_ok[r]  = 1'b0;
      run_done[r] = 1'b0;
    end
    counted = 0;

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening table
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].idx, dir_rows[i].key, dir_rows[i].exh);
      got = merge_step(dir_rows[i].idx, dir_rows[i].key, dir_rows[i].exh, beat);
      if (!dir_rows[i].quiet && got)
        merge_q.push_back(beat);
    end

    // random merge: refill waiting runs, with stray beats mixed in
    while (!all_done) begin
      if ($urandom_range(0, 9) == 0) begin
        run = $urandom_range(0, RUNS - 1);
        key = $urandom();
        exh = ($urandom_range(0, 3) == 0);
      end else begin
        run = pick_waiting();
        // no run awaits a refill: any beat lets the selection go on
        if (run < 0)
          run = $urandom_range(0, RUNS - 1);
        exh = (counted >= RANDOM_ITEMS) || ($urandom_range(0, 8) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: key = $urandom();
          4, 5:       key = $urandom_range(0, 15);
          6:          key = '0;
          7:          key = '1;
          default:    key = head_key[run] + $urandom_range(0, 1000);
        endcase
      end
      ignored = exh ? run_done[run] : (run_done[run] || head_ok[run]);
      if (!ignored)
        counted++;
      send_beat(run[IDX_W-1:0], key, exh);
      got = merge_step(run[IDX_W-1:0], key, exh, beat);
      if (got)
        merge_q.push_back(beat);
    end

    // beats after the done beat must stay silent
    repeat (4) begin
      run = $urandom_range(0, RUNS - 1);
      key = $urandom();
      exh = ($urandom_range(0, 1) == 1);
      send_beat(run[IDX_W-1:0], key, exh);
      got = merge_step(run[IDX_W-1:0], key, exh, beat);
      if (got)
        merge_q.push_back(beat);
    end
    s_tvalid <= 1'b0;

    // drain, then watch for stray beats
    while (merge_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("merged %0d runs: %0d slave beats in, %0d keys and %0d done beat checked",
             RUNS, n_sent, n_keys, n_done);
    $display("%0d mismatches over %0d cycles", fail_cnt, cyc);
    if (fail_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
